>>> rtl/core/shallow_water_grid_step_macros.svh
// Assertion macros shared by the shallow water grid modules.
`ifndef SHALLOW_WATER_GRID_STEP_MACROS_SVH
`define SHALLOW_WATER_GRID_STEP_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define SWG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define SWG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/swg_pkg.sv
// Types, codes and saturating Q16.16 arithmetic for the shallow water grid.
package swg_pkg;

    typedef enum logic [1:0] {
        OP_DEPOSIT = 2'd0,
        OP_STEP    = 2'd1,
        OP_READ    = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        K_DEPOSIT = 2'd0,
        K_STEP    = 2'd1,
        K_READ    = 2'd2,
        K_NOP     = 2'd3
    } t_kind;

    localparam logic [1:0] CFG_VEL  = 2'd0;
    localparam logic [1:0] CFG_HGT  = 2'd1;
    localparam logic [1:0] CFG_DAMP = 2'd2;

    localparam int CFG_W = 31;
    localparam logic [16:0] DAMP_RESET = 17'd65536;
    localparam int Q_DEPTH = 2;

    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]         op;
        logic [5:0]         col;
        logic [5:0]         row;
        logic signed [31:0] amount;
    } t_in;

    typedef struct packed {
        logic signed [31:0] height;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic               saturated;
    } t_out;

    typedef struct packed {
        t_kind              kind;
        logic [5:0]         col;
        logic [5:0]         row;
        logic signed [31:0] amount;
    } t_cmd;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] val;
    } t_sat_val;

    function automatic t_sat_val f_sat33(input logic signed [32:0] x);
        t_sat_val r;
        r.sat = (x[32] != x[31]);
        r.val = r.sat ? (x[32] ? S32_MIN : S32_MAX) : $signed(x[31:0]);
        return r;
    endfunction

    function automatic t_sat_val f_add(input logic signed [31:0] a,
                                       input logic signed [31:0] b);
        logic [32:0] s;
        s = {a[31], a} + {b[31], b};
        return f_sat33($signed(s));
    endfunction

    function automatic t_sat_val f_sub(input logic signed [31:0] a,
                                       input logic signed [31:0] b);
        logic [32:0] s;
        s = {a[31], a} - {b[31], b};
        return f_sat33($signed(s));
    endfunction

    // Unsigned coefficient times signed value, rounded half up, saturated.
    function automatic t_sat_val f_qmul(input logic [31:0] coef,
                                        input logic signed [31:0] b);
        logic signed [64:0] p;
        logic [48:0]        q;
        t_sat_val           r;
        p = $signed({1'b0, coef}) * b;
        p = p + 65'sd32768;
        q = p[64:16];
        r.sat = !((&q[48:31]) || !(|q[48:31]));
        r.val = r.sat ? (q[48] ? S32_MIN : S32_MAX) : $signed(q[31:0]);
        return r;
    endfunction

endpackage

>>> rtl/core/swg_front.sv
// Input stage: takes item transfers, checks the cell and classifies the command.
module swg_front #(
    parameter int GRID_N = 63
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  swg_pkg::t_in  i_in,
    output logic          o_push,
    output swg_pkg::t_cmd o_cmd,
    input  logic          i_full
);
    import swg_pkg::*;

    logic  r_valid;
    t_cmd  r_cmd;
    t_cmd  w_dec;
    logic  w_inside;
    logic  w_accept;

    assign w_inside = (32'(i_in.col) <= GRID_N) && (32'(i_in.row) <= GRID_N);

    always_comb begin
        w_dec.col    = i_in.col;
        w_dec.row    = i_in.row;
        w_dec.amount = i_in.amount;
        case (i_in.op)
            OP_DEPOSIT: w_dec.kind = w_inside ? K_DEPOSIT : K_NOP;
            OP_STEP:    w_dec.kind = K_STEP;
            OP_READ:    w_dec.kind = w_inside ? K_READ : K_NOP;
            default:    w_dec.kind = K_NOP;
        endcase
    end

    assign o_in_stall = r_valid && i_full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_full;
    assign o_cmd      = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= w_dec;
        end
    end

endmodule

>>> rtl/core/swg_queue.sv
// Short command queue between the input stage and the grid engine.
`include "shallow_water_grid_step_macros.svh"
module swg_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  swg_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output swg_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import swg_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);

    t_cmd          r_q [Q_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (PW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    `SWG_ASSERT_NOW(a_no_overflow, i_push, !o_full || i_pop, "queue push while full")
    `SWG_ASSERT_NOW(a_no_underflow, i_pop, o_valid, "queue pop while empty")

endmodule

>>> rtl/core/swg_back.sv
// Grid engine: banked grid memories, clearing pass, deposit, read and step sequencer.
`include "shallow_water_grid_step_macros.svh"
module swg_back #(
    parameter int GRID_N = 63
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [30:0]   i_cfg_data,
    input  logic          i_cmd_valid,
    input  swg_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output swg_pkg::t_out o_out
);
    import swg_pkg::*;

    localparam int SIDE  = GRID_N + 1;
    localparam int CELLS = SIDE * SIDE;
    localparam int DEPTH = 2 * CELLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(SIDE);

    typedef enum logic [14:0] {
        ST_CLEAR  = 15'h0001,
        ST_IDLE   = 15'h0002,
        ST_DEP_RD = 15'h0004,
        ST_DEP_WR = 15'h0008,
        ST_RD_RD  = 15'h0010,
        ST_RD_CAP = 15'h0020,
        ST_S_RD0  = 15'h0040,
        ST_S_RD1  = 15'h0080,
        ST_S_RD2  = 15'h0100,
        ST_S_C0   = 15'h0200,
        ST_S_C1   = 15'h0400,
        ST_S_C2   = 15'h0800,
        ST_S_C3   = 15'h1000,
        ST_S_WR   = 15'h2000,
        ST_DONE   = 15'h4000
    } t_state;

    t_state r_state, n_state;

    logic [30:0] r_cv;
    logic [30:0] r_ch;
    logic [16:0] r_damp;

    logic signed [31:0] r_mem_h [DEPTH];
    logic signed [31:0] r_mem_u [DEPTH];
    logic signed [31:0] r_mem_v [DEPTH];

    logic signed [31:0] r_h_a, r_h_b, r_u_a, r_u_b, r_v_a, r_v_b;

    logic [AW-1:0] r_clr;
    logic          r_bank;
    logic [AW-1:0] r_idx;
    logic [CW-1:0] r_x, r_y;
    t_cmd          r_cmd;
    logic          r_sat;

    logic signed [31:0] r_hw, r_he, r_hn, r_hs, r_hc, r_uw, r_ue, r_uc, r_vn, r_vs, r_vc;
    logic signed [31:0] r_dhx, r_dhy, r_dux, r_dvy;
    logic signed [31:0] r_m1, r_m2, r_div, r_tu, r_tv, r_mh, r_nu, r_nv, r_nh;
    logic signed [31:0] r_res_h, r_res_u, r_res_v;

    logic          r_out_valid;
    t_out          r_out;

    logic [AW-1:0] w_cur_base, w_nxt_base, w_cell, w_ci;
    logic [AW-1:0] w_h_ra, w_h_rb, w_u_ra, w_u_rb, w_v_ra, w_v_rb;
    logic [AW-1:0] w_waddr;
    logic          w_we_h, w_we_uv;
    logic signed [31:0] w_wh, w_wu, w_wv;
    logic          w_slot_free;
    logic          w_last_x, w_last_y;

    t_sat_val w_dep, w_dhx, w_dhy, w_dux, w_dvy, w_m1, w_m2, w_div;
    t_sat_val w_tu, w_tv, w_mh, w_nu, w_nv, w_nh;

    assign w_cur_base = r_bank ? AW'(CELLS) : '0;
    assign w_nxt_base = r_bank ? '0 : AW'(CELLS);
    assign w_cell     = AW'(r_cmd.row) * AW'(SIDE) + AW'(r_cmd.col);
    assign w_ci       = w_cur_base + r_idx;
    assign w_last_x   = (r_x == CW'(GRID_N - 1));
    assign w_last_y   = (r_y == CW'(GRID_N - 1));
    assign w_slot_free = !r_out_valid || !i_out_stall;

    assign o_cmd_pop   = (r_state == ST_IDLE) && i_cmd_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_dep = f_add(r_h_a, r_cmd.amount);
    assign w_dhx = f_sub(r_he, r_hw);
    assign w_dhy = f_sub(r_hs, r_hn);
    assign w_dux = f_sub(r_ue, r_uw);
    assign w_dvy = f_sub(r_vs, r_vn);
    assign w_m1  = f_qmul({1'b0, r_cv}, r_dhx);
    assign w_m2  = f_qmul({1'b0, r_cv}, r_dhy);
    assign w_div = f_add(r_dux, r_dvy);
    assign w_tu  = f_sub(r_uc, r_m1);
    assign w_tv  = f_sub(r_vc, r_m2);
    assign w_mh  = f_qmul({1'b0, r_ch}, r_div);
    assign w_nu  = f_qmul({15'd0, r_damp}, r_tu);
    assign w_nv  = f_qmul({15'd0, r_damp}, r_tv);
    assign w_nh  = f_sub(r_hc, r_mh);

    always_comb begin
        w_h_ra = w_ci;
        w_h_rb = w_ci;
        w_u_ra = w_ci;
        w_u_rb = w_ci;
        w_v_ra = w_ci;
        w_v_rb = w_ci;
        case (r_state)
            ST_DEP_RD, ST_RD_RD: begin
                w_h_ra = w_cur_base + w_cell;
                w_u_ra = w_cur_base + w_cell;
                w_v_ra = w_cur_base + w_cell;
            end
            ST_S_RD0: begin
                w_h_ra = w_ci - AW'(1);
                w_h_rb = w_ci + AW'(1);
                w_u_ra = w_ci - AW'(1);
                w_u_rb = w_ci + AW'(1);
                w_v_ra = w_ci - AW'(SIDE);
                w_v_rb = w_ci + AW'(SIDE);
            end
            ST_S_RD1: begin
                w_h_ra = w_ci - AW'(SIDE);
                w_h_rb = w_ci + AW'(SIDE);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_we_h  = 1'b0;
        w_we_uv = 1'b0;
        w_waddr = w_nxt_base + r_idx;
        w_wh    = r_nh;
        w_wu    = r_nu;
        w_wv    = r_nv;
        case (r_state)
            ST_CLEAR: begin
                w_we_h  = 1'b1;
                w_we_uv = 1'b1;
                w_waddr = r_clr;
                w_wh    = '0;
                w_wu    = '0;
                w_wv    = '0;
            end
            ST_DEP_WR: begin
                w_we_h  = 1'b1;
                w_waddr = w_cur_base + w_cell;
                w_wh    = w_dep.val;
            end
            ST_S_WR: begin
                w_we_h  = 1'b1;
                w_we_uv = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we_h) begin
            r_mem_h[w_waddr] <= w_wh;
        end
        if (w_we_uv) begin
            r_mem_u[w_waddr] <= w_wu;
            r_mem_v[w_waddr] <= w_wv;
        end
        r_h_a <= r_mem_h[w_h_ra];
        r_h_b <= r_mem_h[w_h_rb];
        r_u_a <= r_mem_u[w_u_ra];
        r_u_b <= r_mem_u[w_u_rb];
        r_v_a <= r_mem_v[w_v_ra];
        r_v_b <= r_mem_v[w_v_rb];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:  n_state = (r_clr == AW'(DEPTH - 1)) ? ST_IDLE : ST_CLEAR;
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.kind)
                        K_DEPOSIT: n_state = ST_DEP_RD;
                        K_STEP:    n_state = ST_S_RD0;
                        K_READ:    n_state = ST_RD_RD;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_DEP_RD: n_state = ST_DEP_WR;
            ST_DEP_WR: n_state = ST_DONE;
            ST_RD_RD:  n_state = ST_RD_CAP;
            ST_RD_CAP: n_state = ST_DONE;
            ST_S_RD0:  n_state = ST_S_RD1;
            ST_S_RD1:  n_state = ST_S_RD2;
            ST_S_RD2:  n_state = ST_S_C0;
            ST_S_C0:   n_state = ST_S_C1;
            ST_S_C1:   n_state = ST_S_C2;
            ST_S_C2:   n_state = ST_S_C3;
            ST_S_C3:   n_state = ST_S_WR;
            ST_S_WR:   n_state = (w_last_x && w_last_y) ? ST_DONE : ST_S_RD0;
            ST_DONE:   n_state = w_slot_free ? ST_IDLE : ST_DONE;
            default:   n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_bank      <= 1'b0;
            r_out_valid <= 1'b0;
            r_cv        <= '0;
            r_ch        <= '0;
            r_damp      <= DAMP_RESET;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if ((r_state == ST_S_WR) && w_last_x && w_last_y) begin
                r_bank <= !r_bank;
            end
            if ((r_state == ST_DONE) && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_VEL:  r_cv   <= i_cfg_data;
                    CFG_HGT:  r_ch   <= i_cfg_data;
                    CFG_DAMP: r_damp <= i_cfg_data[16:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    r_cmd   <= i_cmd;
                    r_sat   <= 1'b0;
                    r_res_h <= '0;
                    r_res_u <= '0;
                    r_res_v <= '0;
                    r_idx   <= AW'(SIDE + 1);
                    r_x     <= CW'(1);
                    r_y     <= CW'(1);
                end
            end
            ST_DEP_WR: r_sat <= w_dep.sat;
            ST_RD_CAP: begin
                r_res_h <= r_h_a;
                r_res_u <= r_u_a;
                r_res_v <= r_v_a;
            end
            ST_S_RD1: begin
                r_hw <= r_h_a;
                r_he <= r_h_b;
                r_uw <= r_u_a;
                r_ue <= r_u_b;
                r_vn <= r_v_a;
                r_vs <= r_v_b;
            end
            ST_S_RD2: begin
                r_hn <= r_h_a;
                r_hs <= r_h_b;
                r_uc <= r_u_a;
                r_vc <= r_v_a;
            end
            ST_S_C0: begin
                r_hc  <= r_h_a;
                r_dhx <= w_dhx.val;
                r_dhy <= w_dhy.val;
                r_dux <= w_dux.val;
                r_dvy <= w_dvy.val;
                r_sat <= r_sat | w_dhx.sat | w_dhy.sat | w_dux.sat | w_dvy.sat;
            end
            ST_S_C1: begin
                r_m1  <= w_m1.val;
                r_m2  <= w_m2.val;
                r_div <= w_div.val;
                r_sat <= r_sat | w_m1.sat | w_m2.sat | w_div.sat;
            end
            ST_S_C2: begin
                r_tu  <= w_tu.val;
                r_tv  <= w_tv.val;
                r_mh  <= w_mh.val;
                r_sat <= r_sat | w_tu.sat | w_tv.sat | w_mh.sat;
            end
            ST_S_C3: begin
                r_nu  <= w_nu.val;
                r_nv  <= w_nv.val;
                r_nh  <= w_nh.val;
                r_sat <= r_sat | w_nu.sat | w_nv.sat | w_nh.sat;
            end
            ST_S_WR: begin
                if (w_last_x) begin
                    r_x   <= CW'(1);
                    r_y   <= r_y + CW'(1);
                    r_idx <= r_idx + AW'(3);
                end else begin
                    r_x   <= r_x + CW'(1);
                    r_idx <= r_idx + AW'(1);
                end
            end
            ST_DONE: begin
                if (w_slot_free) begin
                    r_out.height    <= r_res_h;
                    r_out.vel_x     <= r_res_u;
                    r_out.vel_y     <= r_res_v;
                    r_out.saturated <= r_sat;
                end
            end
            default: begin
            end
        endcase
    end

    `SWG_ASSERT_NEXT(a_clear_ends, (r_state == ST_CLEAR) && (r_clr == AW'(DEPTH - 1)), r_state == ST_IDLE, "clearing pass did not end")
    `SWG_ASSERT_NOW(a_step_writes_next_bank, r_state == ST_S_WR, ((AW+1)'(w_waddr) >= (AW+1)'(w_nxt_base)) && ((AW+1)'(w_waddr) < (AW+1)'(w_nxt_base) + (AW+1)'(CELLS)), "step write outside the next bank")
    `SWG_ASSERT_NEXT(a_result_held, (r_state == ST_DONE) && r_out_valid && i_out_stall, r_state == ST_DONE, "result register overwritten")

endmodule

>>> rtl/core/shallow_water_grid_step.sv
// Shallow water grid step: top level joining input stage, command queue and grid engine.
//
// Input items arrive on i_in_valid / o_in_stall with payload i_in; a transfer
// happens on a clock edge with valid high and stall low. Every item gives exactly
// one result on o_out_valid / i_out_stall with payload o_out, in item order.
// Configuration is written through i_cfg_we, i_cfg_index and i_cfg_data; the user
// must write it only while idle; the block itself does not enforce this. After reset
// the grid memories are cleared one address per cycle, 2*(GRID_N+1)^2 addresses
// (8192 at the default size); items queue up meanwhile. A deposit reads the cell and
// writes the saturated sum back; a read reads the cell and captures it. A step visits each
// interior cell in turn through the three read slots and the multiply chain.
// Items are executed one at a time; three more may wait in the input stage and queue.
// While the receiver stalls, the finished result is held and the engine waits
// before loading the next one; input transfers continue until the queue fills.
module shallow_water_grid_step #(
    parameter int GRID_N = 63
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [30:0]   i_cfg_data,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  swg_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output swg_pkg::t_out o_out
);
    import swg_pkg::*;

    logic w_push, w_full, w_q_valid, w_pop;
    t_cmd w_front_cmd, w_q_cmd;

    swg_front #(
        .GRID_N(GRID_N)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_push     (w_push),
        .o_cmd      (w_front_cmd),
        .i_full     (w_full)
    );

    swg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_pop)
    );

    swg_back #(
        .GRID_N(GRID_N)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_cmd_pop   (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the shallow water grid with its own grid predictor.
module tb_top;
    import swg_pkg::*;

    localparam int SIDE = 64;
    localparam int CELLS = SIDE * SIDE;

    typedef struct {
        t_in  item;
        bit   known;
        t_out result;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_VEL;
    logic [30:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in         i_in = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out        o_out;

    int        hgt_bank [2][CELLS];
    int        velx_bank[2][CELLS];
    int        vely_bank[2][CELLS];
    bit        cur_bank;
    longint    vel_coef, hgt_coef, damp;
    bit        clip_seen;
    t_out      pending_results[$];
    int        errors = 0;
    int        transfers = 0, grid_steps = 0, reads_done = 0;
    t_row      rows[$];

    shallow_water_grid_step dut (.*);

    always #10 i_clk = ~i_clk;

    initial begin
        #(20 * 2_000_000);
        $display("TB_ERROR");
        $finish;
    end

    function automatic int clip32(longint x);
        if (x > 64'sd2147483647) begin
            clip_seen = 1'b1;
            return 32'sh7fffffff;
        end
        if (x < -64'sd2147483648) begin
            clip_seen = 1'b1;
            return 32'sh80000000;
        end
        return int'(x);
    endfunction

    function automatic int fix_mul(longint coef, int b);
        longint p;
        p = coef * longint'(b) + 64'sd32768;
        return clip32(p >>> 16);
    endfunction

    function automatic int fix_sub(int a, int b);
        return clip32(longint'(a) - longint'(b));
    endfunction

    function automatic void advance_grid();
        int c, n, i, dhx, dhy, dux, dvy, tu, tv, dv;
        c = cur_bank;
        n = !cur_bank;
        for (int y = 1; y < SIDE - 1; y++) begin
            for (int x = 1; x < SIDE - 1; x++) begin
                i = y * SIDE + x;
                dhx = fix_sub(hgt_bank[c][i + 1], hgt_bank[c][i - 1]);
                dhy = fix_sub(hgt_bank[c][i + SIDE], hgt_bank[c][i - SIDE]);
                dux = fix_sub(velx_bank[c][i + 1], velx_bank[c][i - 1]);
                dvy = fix_sub(vely_bank[c][i + SIDE], vely_bank[c][i - SIDE]);
                tu = fix_sub(velx_bank[c][i], fix_mul(vel_coef, dhx));
                tv = fix_sub(vely_bank[c][i], fix_mul(vel_coef, dhy));
                dv = clip32(longint'(dux) + longint'(dvy));
                velx_bank[n][i] = fix_mul(damp, tu);
                vely_bank[n][i] = fix_mul(damp, tv);
                hgt_bank[n][i] = fix_sub(hgt_bank[c][i], fix_mul(hgt_coef, dv));
            end
        end
        cur_bank = !cur_bank;
    endfunction

    function automatic t_out predict_cell_op(t_in it);
        t_out r;
        int idx;
        r = '0;
        clip_seen = 1'b0;
        idx = int'(it.row) * SIDE + int'(it.col);
        case (t_op'(it.op))
            OP_DEPOSIT: hgt_bank[cur_bank][idx] =
                clip32(longint'(hgt_bank[cur_bank][idx]) + longint'(it.amount));
            OP_STEP: advance_grid();
            OP_READ: begin
                r.height = hgt_bank[cur_bank][idx];
                r.vel_x = velx_bank[cur_bank][idx];
                r.vel_y = vely_bank[cur_bank][idx];
            end
            default: ;
        endcase
        r.saturated = clip_seen;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no expectation waiting");
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (o_out.height !== e.height) begin
                    $error("height: expected %0d, got %0d", e.height, o_out.height);
                    errors++;
                end
                if (o_out.vel_x !== e.vel_x) begin
                    $error("vel_x: expected %0d, got %0d", e.vel_x, o_out.vel_x);
                    errors++;
                end
                if (o_out.vel_y !== e.vel_y) begin
                    $error("vel_y: expected %0d, got %0d", e.vel_y, o_out.vel_y);
                    errors++;
                end
                if (o_out.saturated !== e.saturated) begin
                    $error("saturated: expected %0b, got %0b", e.saturated, o_out.saturated);
                    errors++;
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    initial begin
        int n;
        n = 0;
        forever begin
            @(negedge i_clk);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                n--;
            end else begin
                n = pick_gap();
                i_out_stall <= (n > 0);
                if (n > 0) n--;
            end
        end
    end

    task automatic send_item(t_in it, bit known, t_out res);
        t_out p;
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        p = predict_cell_op(it);
        pending_results.push_back(known ? res : p);
        transfers++;
        if (t_op'(it.op) == OP_STEP) grid_steps++;
        if (t_op'(it.op) == OP_READ) reads_done++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [30:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_VEL:  vel_coef = longint'(val);
            CFG_HGT:  hgt_coef = longint'(val);
            CFG_DAMP: damp = longint'(val[16:0]);
            default: ;
        endcase
    endtask

    function automatic void add_row(t_op op, int c, int r, int amt, bit known,
                                    int h = 0, int u = 0, int v = 0, bit s = 0);
        t_row w;
        w.item.op = op;
        w.item.col = c[5:0];
        w.item.row = r[5:0];
        w.item.amount = amt;
        w.known = known;
        w.result.height = h;
        w.result.vel_x = u;
        w.result.vel_y = v;
        w.result.saturated = s;
        rows.push_back(w);
    endfunction

    function automatic t_in random_item(ref int steps_left);
        t_in it;
        int r;
        r = $urandom_range(0, 99);
        if (r < 5 && steps_left > 0) begin
            it.op = OP_STEP;
            steps_left--;
        end else if (r < 55) it.op = OP_DEPOSIT;
        else if (r < 92) it.op = OP_READ;
        else it.op = OP_NONE;
        if ($urandom_range(0, 9) < 7) begin
            it.col = 6'($urandom_range(0, 8));
            it.row = 6'($urandom_range(0, 8));
        end else begin
            it.col = 6'($urandom_range(0, 63));
            it.row = 6'($urandom_range(0, 63));
        end
        if ($urandom_range(0, 3) == 0) it.amount = $urandom;
        else it.amount = $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
        return it;
    endfunction

    initial begin
        t_out none;
        int steps_left;
        none = '0;
        for (int b = 0; b < 2; b++) begin
            for (int i = 0; i < CELLS; i++) begin
                hgt_bank[b][i] = 0;
                velx_bank[b][i] = 0;
                vely_bank[b][i] = 0;
            end
        end
        cur_bank = 1'b0;
        vel_coef = 0;
        hgt_coef = 0;
        damp = 65536;

        add_row(OP_READ, 0, 0, 0, 1);
        add_row(OP_READ, 63, 63, -1, 1);
        add_row(OP_DEPOSIT, 10, 10, 32'sh7fffffff, 1);
        add_row(OP_DEPOSIT, 10, 10, 1, 1, 0, 0, 0, 1);
        add_row(OP_READ, 10, 10, 0, 1, 32'sh7fffffff);
        add_row(OP_DEPOSIT, 11, 10, 32'sh80000000, 1);
        add_row(OP_DEPOSIT, 11, 10, -1, 1, 0, 0, 0, 1);
        add_row(OP_DEPOSIT, 12, 20, 32'sh00010000, 0);
        add_row(OP_DEPOSIT, 0, 20, 32'sh55555555, 0);
        add_row(OP_DEPOSIT, 63, 0, 32'shaaaaaaaa, 0);
        add_row(OP_NONE, 63, 63, -1, 1);
        add_row(OP_STEP, 0, 0, 0, 0);
        add_row(OP_READ, 10, 10, 0, 0);
        add_row(OP_READ, 0, 20, 0, 0);
        add_row(OP_STEP, 63, 63, 0, 0);
        add_row(OP_READ, 0, 20, 0, 0);
        add_row(OP_READ, 12, 20, 0, 0);
        add_row(OP_READ, 63, 0, 0, 0);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k]) send_item(rows[k].item, rows[k].known, rows[k].result);

        for (int ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0: begin
                    write_reg(CFG_VEL, 31'h0000_4000);
                    write_reg(CFG_HGT, 31'h0000_2000);
                    write_reg(CFG_DAMP, 31'h0001_0000);
                end
                1: begin
                    write_reg(CFG_VEL, 31'h7fff_ffff);
                    write_reg(CFG_HGT, 31'h7fff_ffff);
                    write_reg(CFG_DAMP, 31'h0000_0000);
                end
                2: begin
                    write_reg(CFG_VEL, 31'($urandom));
                    write_reg(CFG_HGT, 31'($urandom_range(0, 32'h20000)));
                    write_reg(CFG_DAMP, 31'h0001_ffff);
                end
                default: begin
                    write_reg(CFG_VEL, 31'($urandom_range(0, 32'h10000)));
                    write_reg(CFG_HGT, 31'($urandom_range(0, 32'h10000)));
                    write_reg(CFG_DAMP, 31'($urandom_range(0, 65536)));
                end
            endcase
            steps_left = 2;
            for (int k = 0; k < 25; k++) begin
                if (ph == 1 && k == 12) drain();
                if (k == 3 && steps_left == 2) begin
                    t_in st;
                    st = '0;
                    st.op = OP_STEP;
                    steps_left--;
                    send_item(st, 0, none);
                end else begin
                    send_item(random_item(steps_left), 0, none);
                end
            end
        end

        drain();
        $display("Covered %0d transfers: %0d grid steps, %0d reads, four coefficient settings.",
                 transfers, grid_steps, reads_done);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl/core
rtl/core/swg_pkg.sv
rtl/core/swg_front.sv
rtl/core/swg_queue.sv
rtl/core/swg_back.sv
rtl/core/shallow_water_grid_step.sv
sim/tb_top.sv
